// File: src/kpl_pkg.sv
package kpl_pkg;

  // code length in digits, default for the top level
  localparam int unsigned CodeDigitsDef = 4;

  // field and register widths
  localparam int unsigned KeyW   = 8;
  localparam int unsigned EventW = 3;
  localparam int unsigned HeldW  = 3;
  localparam int unsigned RegW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DigitW = 4;

  // register reset values
  localparam logic [RegW-1:0] UnlockCodeRst  = 16'h1234;
  localparam logic [RegW-1:0] WipeCodeRst    = 16'h9999;
  localparam logic [RegW-1:0] IdleTimeoutRst = 16'd5000;

  // key characters
  localparam logic [KeyW-1:0] KeyHash = 8'h23;
  localparam logic [KeyW-1:0] KeyZero = 8'h30;
  localparam logic [KeyW-1:0] KeyNine = 8'h39;

  // item kinds
  typedef enum logic {
    KIND_KEY  = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  // result events
  typedef enum logic [EventW-1:0] {
    EV_NONE    = 3'd0,
    EV_DIGIT   = 3'd1,
    EV_UNLOCK  = 3'd2,
    EV_WIPE    = 3'd3,
    EV_WRONG   = 3'd4,
    EV_REJECT  = 3'd5,
    EV_TIMEOUT = 3'd6
  } event_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_UNLOCK_CODE  = 2'd0,
    CFG_WIPE_CODE    = 2'd1,
    CFG_IDLE_TIMEOUT = 2'd2
  } cfg_idx_e;

endpackage

// File: src/kpl_if.sv
interface kpl_in_if import kpl_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            kind;
  logic [KeyW-1:0] key_char;

  modport source (output valid, output kind, output key_char, input ready);
  modport sink (input valid, input kind, input key_char, output ready);
endinterface

interface kpl_out_if import kpl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [EventW-1:0] event_res;
  logic [HeldW-1:0]  digits_held;

  modport source (output valid, output event_res, output digits_held, input ready);
  modport sink (input valid, input event_res, input digits_held, output ready);
endinterface

interface kpl_cfg_if import kpl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [RegW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/keypad_pin_code_lock_core.sv
// keypad pin code lock
// in_i carries one item per handshake: kind (0 key press, 1 millisecond tick)
// and key_char, the ascii code of the key. out_o returns exactly one item for
// every input item: event_res and digits_held, the digit count after the item.
// cfg_i writes unlock_code (index 0), wipe_code (index 1) and idle_timeout
// (index 2); other indexes are accepted and dropped. cfg_i is always ready and
// is meant to be written while the block is idle.
// the result is registered and valid in the cycle after an item is accepted.
// throughput: one item per cycle while the receiver takes each result; the
// whole update of the digit store, count and idle timer is one pass of logic
// between the input handshake and the result register.
// when the receiver stalls, the result register holds its item and in_i.ready
// drops; the next item is taken in the same cycle the held result leaves.
// reset clears the entry, sets the registers to 0x1234, 0x9999 and 5000 and
// arms the idle timer at zero ticks; no result is pending after reset.
module keypad_pin_code_lock_core import kpl_pkg::*; #(
  parameter int unsigned CODE_DIGITS = CodeDigitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kpl_in_if.sink    in_i,
  kpl_out_if.source out_o,
  kpl_cfg_if.sink   cfg_i
);

  localparam int unsigned CntW  = $clog2(CODE_DIGITS + 1);
  localparam int unsigned CodeW = DigitW * CODE_DIGITS;

  // configuration registers
  logic [RegW-1:0] unlock_code_q, wipe_code_q, idle_timeout_q;

  // entry and timer state
  logic [DigitW-1:0] store_q [CODE_DIGITS];
  logic [DigitW-1:0] store_d [CODE_DIGITS];
  logic [CntW-1:0]   count_q, count_d;
  logic [RegW-1:0]   ticks_q, ticks_d;
  logic              armed_q, armed_d;

  // result register
  logic             out_valid_q, out_valid_d;
  event_e           ev_q, ev_d;
  logic [HeldW-1:0] held_q, held_d;

  logic in_acc;
  logic is_digit, room_left, unlock_hit, wipe_hit;
  logic [RegW-1:0] tick_inc, tick_limit;
  logic [CntW+HeldW-1:0] held_ext;

  // result register frees when taken: an item enters every cycle unless stalled
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // compare held digits against a code, first digit in the top nibble;
  // nibbles above the register width read as zero
  function automatic logic code_match(
    input logic [RegW-1:0]   code,
    input logic [DigitW-1:0] digits [CODE_DIGITS],
    input logic [CntW-1:0]   cnt
  );
    logic [CodeW+RegW-1:0] ext;
    logic                  hit;
    ext = {{CodeW{1'b0}}, code};
    hit = (cnt == CntW'(CODE_DIGITS));
    for (int unsigned i = 0; i < CODE_DIGITS; i++) begin
      if (digits[i] != ext[DigitW*(CODE_DIGITS-1-i) +: DigitW]) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  assign is_digit   = (in_i.key_char >= KeyZero) && (in_i.key_char <= KeyNine);
  assign room_left  = (count_q < CntW'(CODE_DIGITS));
  assign unlock_hit = code_match(unlock_code_q, store_q, count_q);
  assign wipe_hit   = code_match(wipe_code_q, store_q, count_q);

  // tick counter saturates at all ones; a zero timeout acts like one
  assign tick_inc   = (ticks_q != {RegW{1'b1}}) ? ticks_q + RegW'(1) : ticks_q;
  assign tick_limit = (idle_timeout_q != '0) ? idle_timeout_q : RegW'(1);

  // next entry, timer and event for the item at the input
  always_comb begin
    store_d = store_q;
    count_d = count_q;
    ticks_d = ticks_q;
    armed_d = armed_q;
    ev_d    = EV_NONE;
    if (in_i.kind == KIND_TICK) begin
      if (armed_q) begin
        if (tick_inc >= tick_limit) begin
          for (int unsigned i = 0; i < CODE_DIGITS; i++) begin
            store_d[i] = '0;
          end
          count_d = '0;
          armed_d = 1'b0;
          ticks_d = '0;
          ev_d    = EV_TIMEOUT;
        end else begin
          ticks_d = tick_inc;
        end
      end
    end else begin
      // any key restarts the timer, rejected ones too
      ticks_d = '0;
      armed_d = 1'b1;
      if (in_i.key_char == KeyHash) begin
        if (unlock_hit) begin
          ev_d = EV_UNLOCK;
        end else if (wipe_hit) begin
          ev_d = EV_WIPE;
        end else begin
          ev_d = EV_WRONG;
        end
        for (int unsigned i = 0; i < CODE_DIGITS; i++) begin
          store_d[i] = '0;
        end
        count_d = '0;
      end else if (is_digit && room_left) begin
        for (int unsigned i = 0; i < CODE_DIGITS; i++) begin
          if (count_q == CntW'(i)) begin
            store_d[i] = DigitW'(in_i.key_char - KeyZero);
          end
        end
        count_d = count_q + CntW'(1);
        ev_d    = EV_DIGIT;
      end else begin
        ev_d = EV_REJECT;
      end
    end
  end

  // digit count as reported: low bits of the count
  assign held_ext = {{HeldW{1'b0}}, count_d};
  assign held_d   = held_ext[HeldW-1:0];

  always_comb begin
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unlock_code_q  <= UnlockCodeRst;
      wipe_code_q    <= WipeCodeRst;
      idle_timeout_q <= IdleTimeoutRst;
      for (int unsigned i = 0; i < CODE_DIGITS; i++) begin
        store_q[i] <= '0;
      end
      count_q     <= '0;
      ticks_q     <= '0;
      armed_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        store_q <= store_d;
        count_q <= count_d;
        ticks_q <= ticks_d;
        armed_q <= armed_d;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          CFG_UNLOCK_CODE:  unlock_code_q  <= cfg_i.data;
          CFG_WIPE_CODE:    wipe_code_q    <= cfg_i.data;
          CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  // result payload, loaded with each accepted item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ev_q   <= ev_d;
      held_q <= held_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.event_res   = ev_q;
  assign out_o.digits_held = held_q;

  // entry never grows past the code length
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CODE_DIGITS))
    else $error("digit count beyond code length");

  // an accepted item always leaves a result behind
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted item produced no result");

  // a disarmed timer sits at zero ticks
  a_disarmed_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !armed_q |-> ticks_q == '0)
    else $error("tick count moved while timer disarmed");

  // timeout clears the entry and disarms the timer
  a_timeout_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ev_d == EV_TIMEOUT |=> !armed_q && count_q == '0)
    else $error("timeout left entry or timer active");

  // a taken digit adds exactly one to the count
  a_digit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ev_d == EV_DIGIT |=> count_q == $past(count_q) + CntW'(1))
    else $error("digit taken without count step");

endmodule
